// ===== design/aamd_pkg.sv =====
// Shared types and constants for the alpha-aware mipmap downsampler.
`default_nettype none
package aamd_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_WIDTH_LOG2      = 2'd0;
   localparam logic [1:0] CSR_HEIGHT_LOG2     = 2'd1;
   localparam logic [1:0] CSR_ALPHA_THRESHOLD = 2'd2;

   // Register reset values and size limits
   localparam logic [3:0] WIDTH_LOG2_RESET  = 4'd8;
   localparam logic [3:0] HEIGHT_LOG2_RESET = 4'd8;
   localparam logic [7:0] ALPHA_THR_RESET   = 8'd16;
   localparam logic [3:0] LOG2_MIN          = 4'd1;
   localparam logic [3:0] LOG2_MAX          = 4'd12;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Horizontal pair sum, one line store entry
   typedef struct packed {
      logic [8:0] r;
      logic [8:0] g;
      logic [8:0] b;
      logic [8:0] a;
      logic [1:0] n;
   } sums_type;

   // Full 2x2 quad sums plus output flags, one queue entry
   typedef struct packed {
      logic [9:0] r;
      logic [9:0] g;
      logic [9:0] b;
      logic [9:0] a;
      logic [2:0] n;
      logic       eor;
      logic       eof;
   } quad_type;

endpackage
`default_nettype wire

// ===== design/alpha_aware_mipmap_downsample.sv =====
// Path: a quad's last pixel passes stage A, the queue and the output register.
// Throughput: one pixel per cycle, set by the single-port line store and the
// one-item-per-cycle queue; input stalls only when the output side stalls and the
// 4-entry queue fills.
// Reset: counters, left pixel and queue clear; registers go to 8, 8, 16. The line
// store is not cleared: each odd row reads only what the even row above it wrote.
`default_nettype none
module alpha_aware_mipmap_downsample #(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_red_in,
   input  wire logic [7:0] req_green_in,
   input  wire logic [7:0] req_blue_in,
   input  wire logic [7:0] req_alpha_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_red_out,
   output logic [7:0]      rsp_green_out,
   output logic [7:0]      rsp_blue_out,
   output logic [7:0]      rsp_alpha_out,
   output logic            rsp_end_of_row,
   output logic            rsp_end_of_frame,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);

   logic                push_valid, pop, pop_valid;
   aamd_pkg::quad_type  push_item, pop_item;
   logic [$clog2(aamd_pkg::QUEUE_DEPTH+1)-1:0] queue_level;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   aamd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .req_alpha_in (req_alpha_in),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .queue_level  (queue_level),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   aamd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .level      (queue_level)
   );

   aamd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_item         (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_alpha_out    (rsp_alpha_out),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule
`default_nettype wire

// ===== design/aamd_front.sv =====
// Front end: pixel accept, masking, raster counters, line store and quad sums.
`default_nettype none
module aamd_front #(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // pixel input
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_red_in,
   input  wire logic [7:0]          req_green_in,
   input  wire logic [7:0]          req_blue_in,
   input  wire logic [7:0]          req_alpha_in,
   // configuration
   input  wire logic                csr_valid,
   input  wire logic [1:0]          csr_index,
   input  wire logic [7:0]          csr_data,
   // queue side
   input  wire logic [$clog2(aamd_pkg::QUEUE_DEPTH+1)-1:0] queue_level,
   output logic                     push_valid,
   output aamd_pkg::quad_type       push_item
);

   localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int SLOTS   = MAX_WIDTH / 2;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LVL_W   = $clog2(aamd_pkg::QUEUE_DEPTH + 1);

   // configuration registers
   logic [3:0] width_log2_ff, height_log2_ff;
   logic [7:0] alpha_thr_ff;

   // raster state
   logic [COL_W-1:0]    col_ff, col_in;
   logic [11:0]         row_ff, row_in;
   aamd_pkg::sums_type  left_ff, left_in;

   // stage A registers
   logic                pipe_valid_ff;
   aamd_pkg::sums_type  pipe_sum_ff;
   logic                pipe_eor_ff, pipe_eof_ff;
   aamd_pkg::sums_type  rd_ff;

   // line store of even-row pair sums
   aamd_pkg::sums_type  line_mem [SLOTS];

   logic                accept;
   logic [3:0]          wl_clamp, hl_clamp;
   logic [12:0]         width_full, width_less;
   logic [COL_W-1:0]    col_last;
   logic [11:0]         row_last;
   logic [11:0]         height_less;
   aamd_pkg::sums_type  px, pair;
   logic [SLOT_W-1:0]   slot;
   logic                col_odd, row_odd, eor, eof;
   logic [LVL_W:0]      occupancy;

   // hold input while the queue cannot take the item in flight plus one more
   always_comb begin
      occupancy = {1'b0, queue_level} + {{LVL_W{1'b0}}, pipe_valid_ff};
      req_stall = (occupancy >= (LVL_W+1)'(aamd_pkg::QUEUE_DEPTH));
   end
   assign accept = req_valid && !req_stall;

   // effective image size from the log2 registers
   always_comb begin
      wl_clamp = (width_log2_ff < aamd_pkg::LOG2_MIN) ? aamd_pkg::LOG2_MIN :
                 (width_log2_ff > aamd_pkg::LOG2_MAX) ? aamd_pkg::LOG2_MAX : width_log2_ff;
      hl_clamp = (height_log2_ff < aamd_pkg::LOG2_MIN) ? aamd_pkg::LOG2_MIN :
                 (height_log2_ff > aamd_pkg::LOG2_MAX) ? aamd_pkg::LOG2_MAX : height_log2_ff;
      width_full = 13'd1 << wl_clamp;
      width_less = width_full - 13'd1;
      if (width_full > 13'(MAX_WIDTH)) begin
         col_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         col_last = width_less[COL_W-1:0];
      end
      height_less = 12'((13'd1 << hl_clamp) - 13'd1);
      row_last    = height_less;
   end

   // masked pixel, pair sum and position flags
   always_comb begin
      px = '0;
      if (req_alpha_in >= alpha_thr_ff) begin
         px.r = {1'b0, req_red_in};
         px.g = {1'b0, req_green_in};
         px.b = {1'b0, req_blue_in};
         px.a = {1'b0, req_alpha_in};
         px.n = 2'd1;
      end
      pair.r = left_ff.r + px.r;
      pair.g = left_ff.g + px.g;
      pair.b = left_ff.b + px.b;
      pair.a = left_ff.a + px.a;
      pair.n = left_ff.n + px.n;
      slot    = SLOT_W'((col_ff >> 1) & COL_W'(SLOTS - 1));
      col_odd = col_ff[0];
      row_odd = row_ff[0];
      eor     = (col_ff == col_last);
      eof     = eor && (row_ff == row_last);
   end

   // next raster position and left pixel; a size write restarts the frame
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (accept) begin
         if (!col_odd) begin
            left_in = px;
         end
         if (eor) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? 12'd0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      if (csr_valid && (csr_index inside {aamd_pkg::CSR_WIDTH_LOG2,
                                          aamd_pkg::CSR_HEIGHT_LOG2})) begin
         col_in = '0;
         row_in = '0;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= aamd_pkg::WIDTH_LOG2_RESET;
         height_log2_ff <= aamd_pkg::HEIGHT_LOG2_RESET;
         alpha_thr_ff   <= aamd_pkg::ALPHA_THR_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
         left_ff        <= '0;
         pipe_valid_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_ff       <= left_in;
         pipe_valid_ff <= accept && col_odd && row_odd;
         if (csr_valid) begin
            unique case (csr_index)
               aamd_pkg::CSR_WIDTH_LOG2: begin
                  width_log2_ff <= csr_data[3:0];
               end
               aamd_pkg::CSR_HEIGHT_LOG2: begin
                  height_log2_ff <= csr_data[3:0];
               end
               aamd_pkg::CSR_ALPHA_THRESHOLD: begin
                  alpha_thr_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // line store access and stage A payload
   always_ff @(posedge clock) begin
      if (accept && col_odd) begin
         if (row_odd) begin
            rd_ff       <= line_mem[slot];
            pipe_sum_ff <= pair;
            pipe_eor_ff <= eor;
            pipe_eof_ff <= eof;
         end else begin
            line_mem[slot] <= pair;
         end
      end
   end

   // quad sum into the queue
   always_comb begin
      push_valid     = pipe_valid_ff;
      push_item.r    = {1'b0, pipe_sum_ff.r} + {1'b0, rd_ff.r};
      push_item.g    = {1'b0, pipe_sum_ff.g} + {1'b0, rd_ff.g};
      push_item.b    = {1'b0, pipe_sum_ff.b} + {1'b0, rd_ff.b};
      push_item.a    = {1'b0, pipe_sum_ff.a} + {1'b0, rd_ff.a};
      push_item.n    = {1'b0, pipe_sum_ff.n} + {1'b0, rd_ff.n};
      push_item.eor  = pipe_eor_ff;
      push_item.eof  = pipe_eof_ff;
   end

endmodule
`default_nettype wire

// ===== design/aamd_queue.sv =====
// Short register queue of quad sums between front and back.
`default_nettype none
module aamd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire aamd_pkg::quad_type  push_item,
   input  wire logic                pop,
   output logic                     pop_valid,
   output aamd_pkg::quad_type       pop_item,
   output logic [$clog2(aamd_pkg::QUEUE_DEPTH+1)-1:0] level
);

   localparam int DEPTH = aamd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   aamd_pkg::quad_type  slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [LVL_W-1:0]    level_ff;
   logic                do_pop;

   assign do_pop    = pop && (level_ff != '0);
   assign pop_valid = (level_ff != '0);
   assign pop_item  = slots_ff[rd_ptr_ff];
   assign level     = level_ff;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push_valid && !do_pop) begin
            level_ff <= level_ff + LVL_W'(1);
         end else if (!push_valid && do_pop) begin
            level_ff <= level_ff - LVL_W'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== design/aamd_back.sv =====
// Back end: divide colour quad sums by used count, alpha by four, and hold the result item.
`default_nettype none
module aamd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   input  wire aamd_pkg::quad_type  pop_item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_red_out,
   output logic [7:0]               rsp_green_out,
   output logic [7:0]               rsp_blue_out,
   output logic [7:0]               rsp_alpha_out,
   output logic                     rsp_end_of_row,
   output logic                     rsp_end_of_frame
);

   // x*683 >> 11 equals x/3 for every x below 2048
   localparam logic [9:0] RECIP3 = 10'd683;

   logic       valid_ff;
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic       eor_ff, eof_ff;
   logic       load;

   // average of a quad channel over n used pixels, n in 0..4
   function automatic logic [7:0] quad_avg(input logic [9:0] sum, input logic [2:0] n);
      logic [19:0] prod;
      logic [9:0]  q;
      prod = {10'd0, sum} * {10'd0, RECIP3};
      case (n)
         3'd1:    q = sum;
         3'd2:    q = sum >> 1;
         3'd3:    q = prod[19:11] == 9'd0 ? 10'd0 : {1'b0, prod[19:11]};
         3'd4:    q = sum >> 2;
         default: q = 10'd0;
      endcase
      return q[7:0];
   endfunction

   assign load = pop_valid && (!valid_ff || !rsp_stall);
   assign pop  = load;

   // output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= quad_avg(pop_item.r, pop_item.n);
         green_ff <= quad_avg(pop_item.g, pop_item.n);
         blue_ff  <= quad_avg(pop_item.b, pop_item.n);
         alpha_ff <= pop_item.a[9:2];
         eor_ff   <= pop_item.eor;
         eof_ff   <= pop_item.eof;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_red_out      = red_ff;
   assign rsp_green_out    = green_ff;
   assign rsp_blue_out     = blue_ff;
   assign rsp_alpha_out    = alpha_ff;
   assign rsp_end_of_row   = eor_ff;
   assign rsp_end_of_frame = eof_ff;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the alpha-aware 2x2 mipmap downsampler.
`timescale 1ns / 100ps

module testbench;

   localparam int LINE_MAX_WIDTH = 4096;
   localparam int LINE_SLOTS     = LINE_MAX_WIDTH / 2;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 500;
   localparam int EDGE_ITEMS     = 128;
   localparam int NO_IDLE_ITEMS  = 256;
   // csr_index code that maps to no register
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       end_of_row;
      logic       end_of_frame;
   } mip_pixel_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_red_in = 8'd0;
   logic [7:0] req_green_in = 8'd0;
   logic [7:0] req_blue_in = 8'd0;
   logic [7:0] req_alpha_in = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic [7:0] rsp_alpha_out;
   logic       rsp_end_of_row;
   logic       rsp_end_of_frame;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_data = 8'd0;

   int            error_count = 0;
   bit            no_idle = 1'b0;
   mip_pixel_type expected_pixels[$];
   mip_pixel_type next_due;

   // Predictor state
   logic [3:0]          width_log2_q  = aamd_pkg::WIDTH_LOG2_RESET;
   logic [3:0]          height_log2_q = aamd_pkg::HEIGHT_LOG2_RESET;
   logic [7:0]          alpha_thr_q   = aamd_pkg::ALPHA_THR_RESET;
   int unsigned         col_pos = 0;
   int unsigned         row_pos = 0;
   aamd_pkg::sums_type  left_pixel = '0;
   aamd_pkg::sums_type  pair_line [0:LINE_SLOTS-1];

   alpha_aware_mipmap_downsample #(.MAX_WIDTH(LINE_MAX_WIDTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_alpha_in     (req_alpha_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_alpha_out    (rsp_alpha_out),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // Image side in pixels from a log2 register whose value is clamped to 1..12
   function automatic int unsigned side_px(input logic [3:0] l2);
      int unsigned v;
      v = 32'((l2 < aamd_pkg::LOG2_MIN) ? aamd_pkg::LOG2_MIN :
              (l2 > aamd_pkg::LOG2_MAX) ? aamd_pkg::LOG2_MAX : l2);
      v = 1 << v;
      return (v > LINE_MAX_WIDTH) ? LINE_MAX_WIDTH : v;
   endfunction

   function automatic logic [7:0] used_mean(input int unsigned sum, input int unsigned cnt);
      return (cnt == 0) ? 8'd0 : 8'((sum / cnt) & 8'hFF);
   endfunction

   // Advance the downsampler by one source pixel; returns 1 when a quad completes
   function automatic bit predict_mip(input rgba_type src, output mip_pixel_type res);
      int unsigned         w;
      int unsigned         h;
      int unsigned         slot;
      int unsigned         cnt;
      aamd_pkg::sums_type  px;
      aamd_pkg::sums_type  pair;
      bit                  produced;
      w = side_px(width_log2_q);
      h = side_px(height_log2_q);
      produced = 1'b0;
      res = '0;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;

      // masked pixel: ignored entirely below threshold
      px = '0;
      if (src.alpha >= alpha_thr_q) begin
         px.r = {1'b0, src.red};
         px.g = {1'b0, src.green};
         px.b = {1'b0, src.blue};
         px.a = {1'b0, src.alpha};
         px.n = 2'd1;
      end

      slot = (col_pos >> 1) & (LINE_SLOTS - 1);
      if ((col_pos & 1) == 0) begin
         left_pixel = px;
      end else begin
         pair.r = left_pixel.r + px.r;
         pair.g = left_pixel.g + px.g;
         pair.b = left_pixel.b + px.b;
         pair.a = left_pixel.a + px.a;
         pair.n = left_pixel.n + px.n;
         if ((row_pos & 1) == 0) begin
            pair_line[slot] = pair;
         end else begin
            cnt = int'(pair.n) + int'(pair_line[slot].n);
            res.red   = used_mean(int'(pair.r) + int'(pair_line[slot].r), cnt);
            res.green = used_mean(int'(pair.g) + int'(pair_line[slot].g), cnt);
            res.blue  = used_mean(int'(pair.b) + int'(pair_line[slot].b), cnt);
            res.alpha = 8'(((int'(pair.a) + int'(pair_line[slot].a)) / 4) & 8'hFF);
            res.end_of_row   = (col_pos == w - 1);
            res.end_of_frame = (col_pos == w - 1) && (row_pos == h - 1);
            produced = 1'b1;
         end
      end

      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
      return produced;
   endfunction

   // Random pixel with alpha biased around the current threshold
   function automatic rgba_type rand_pixel();
      rgba_type p;
      p.red   = 8'($urandom);
      p.green = 8'($urandom);
      p.blue  = 8'($urandom);
      case ($urandom_range(3))
         0: p.alpha = alpha_thr_q;
         1: p.alpha = (alpha_thr_q == 0) ? 8'd0 : 8'($urandom_range(alpha_thr_q - 1));
         default: p.alpha = 8'($urandom);
      endcase
      return p;
   endfunction

   function automatic logic [7:0] rand_threshold();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Send one pixel item, with a random gap before it
   task automatic send_pixel(input rgba_type src);
      int unsigned   gap;
      mip_pixel_type res;
      gap = 0;
      while (!no_idle && $urandom_range(99) < 31) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= src.red;
      req_green_in <= src.green;
      req_blue_in  <= src.blue;
      req_alpha_in <= src.alpha;
      do @(posedge clock); while (req_stall);
      if (predict_mip(src, res)) expected_pixels.push_back(res);
   endtask

   task automatic send_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_pixel(rand_pixel());
   endtask

   // Stop sending, let every expected item arrive, then let the pipeline drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      // size writes restart the frame
      case (index)
         aamd_pkg::CSR_WIDTH_LOG2: begin
            width_log2_q = value[3:0];
            col_pos = 0;
            row_pos = 0;
         end
         aamd_pkg::CSR_HEIGHT_LOG2: begin
            height_log2_q = value[3:0];
            col_pos = 0;
            row_pos = 0;
         end
         aamd_pkg::CSR_ALPHA_THRESHOLD: alpha_thr_q = value;
         default: ;
      endcase
   endtask

   // Two rows of the 256x256 image that reset selects, threshold 16
   task automatic test_reset_defaults();
      send_random(2 * side_px(width_log2_q));
   endtask

   // Hand-built 2x2 images: full, empty, threshold edge, truncation
   task automatic test_quad_cases();
      write_csr(aamd_pkg::CSR_WIDTH_LOG2, 8'd1);
      write_csr(aamd_pkg::CSR_HEIGHT_LOG2, 8'd1);
      write_csr(aamd_pkg::CSR_ALPHA_THRESHOLD, 8'd16);
      repeat (4) send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
      repeat (4) send_pixel({8'hFF, 8'hFF, 8'hFF, 8'h00});
      send_pixel({8'd200, 8'd100, 8'd50, 8'd16});
      send_pixel({8'd255, 8'd255, 8'd255, 8'd15});
      send_pixel({8'd101, 8'd3, 8'd0, 8'd16});
      send_pixel({8'd7, 8'd9, 8'd11, 8'd15});
      write_csr(aamd_pkg::CSR_ALPHA_THRESHOLD, 8'd0);
      repeat (4) send_pixel({8'd0, 8'd0, 8'd0, 8'd0});
      send_pixel({8'd1, 8'd0, 8'd3, 8'd0});
      send_pixel({8'd2, 8'd1, 8'd3, 8'd0});
      send_pixel({8'd2, 8'd1, 8'd3, 8'd0});
      send_pixel({8'd2, 8'd1, 8'd2, 8'd1});
      write_csr(aamd_pkg::CSR_ALPHA_THRESHOLD, 8'hFF);
      send_pixel({8'd10, 8'd20, 8'd30, 8'hFE});
      send_pixel({8'd90, 8'd80, 8'd70, 8'hFE});
      send_pixel({8'd99, 8'd98, 8'd97, 8'hFE});
      send_pixel({8'd10, 8'd20, 8'd30, 8'hFF});
      send_pixel({8'd255, 8'd1, 8'd0, 8'hFF});
      send_pixel({8'd255, 8'd2, 8'd0, 8'hFF});
      send_pixel({8'd254, 8'd2, 8'd1, 8'hFF});
      send_pixel({8'd0, 8'd0, 8'd0, 8'h00});
   endtask

   // Size clamping, unused register index, start of the widest and tallest images
   task automatic test_size_limits();
      write_csr(aamd_pkg::CSR_WIDTH_LOG2, 8'h00);
      write_csr(aamd_pkg::CSR_HEIGHT_LOG2, 8'h00);
      write_csr(aamd_pkg::CSR_ALPHA_THRESHOLD, 8'h80);
      send_random(8);
      write_csr(CSR_UNUSED, 8'hA5);
      send_random(4);
      write_csr(aamd_pkg::CSR_WIDTH_LOG2, 8'hFF);
      write_csr(aamd_pkg::CSR_HEIGHT_LOG2, 8'hF0);
      send_random(EDGE_ITEMS);
      write_csr(aamd_pkg::CSR_WIDTH_LOG2, 8'hF1);
      write_csr(aamd_pkg::CSR_HEIGHT_LOG2, 8'h0C);
      send_random(EDGE_ITEMS);
   endtask

   // Random small images: whole frames, back-to-back frames and cut-off frames
   task automatic test_random_frames();
      int unsigned sent;
      int unsigned phase;
      int unsigned frame_px;
      int unsigned count;
      logic [7:0]  size_word;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle = (phase == 1);
         // sometimes keep the geometry and carry on mid-frame
         if (phase == 0 || $urandom_range(3) != 0) begin
            size_word = 8'($urandom);
            size_word[3:0] = 4'($urandom_range(4));
            write_csr(aamd_pkg::CSR_WIDTH_LOG2, size_word);
            size_word = 8'($urandom);
            size_word[3:0] = 4'($urandom_range(4));
            write_csr(aamd_pkg::CSR_HEIGHT_LOG2, size_word);
         end
         write_csr(aamd_pkg::CSR_ALPHA_THRESHOLD, rand_threshold());
         frame_px = side_px(width_log2_q) * side_px(height_log2_q);
         case ($urandom_range(2))
            0: count = frame_px;
            1: count = 2 * frame_px;
            default: count = $urandom_range(2 * frame_px, 1);
         endcase
         // the stretch without idling runs long
         if (phase == 1 && count < NO_IDLE_ITEMS) count = NO_IDLE_ITEMS;
         for (int unsigned i = 0; i < count; i++) begin
            // hold off until the output side has caught up
            if (phase == 0 && i == count / 2) wait_idle();
            send_pixel(rand_pixel());
         end
         sent += count;
         phase++;
      end
      no_idle = 1'b0;
   endtask

   // Output side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 31);
      end
   end

   function automatic void check_field(input string label, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   // Compare every accepted result item with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: result item with none expected, expected none actual %h",
                     $time, {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out});
            error_count++;
         end else begin
            next_due = expected_pixels.pop_front();
            check_field("red_out", next_due.red, rsp_red_out);
            check_field("green_out", next_due.green, rsp_green_out);
            check_field("blue_out", next_due.blue, rsp_blue_out);
            check_field("alpha_out", next_due.alpha, rsp_alpha_out);
            check_field("end_of_row", next_due.end_of_row, rsp_end_of_row);
            check_field("end_of_frame", next_due.end_of_frame, rsp_end_of_frame);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_quad_cases();
      test_size_limits();
      test_random_frames();
      wait_idle();
      if (expected_pixels.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
design/aamd_pkg.sv
design/aamd_front.sv
design/aamd_queue.sv
design/aamd_back.sv
design/alpha_aware_mipmap_downsample.sv
tb/sv/testbench.sv
